@@ sv/rep_pkg.sv @@
package rep_pkg;

  // Fixed field widths
  localparam int SAMPLE_W = 13;
  localparam int IDX_W    = 9;
  localparam int THR_W    = 12;
  localparam int CNT_W    = 9;
  localparam int WEND_W   = 10;
  localparam int ALU_W    = 20;
  localparam int CFG_AW   = 5;
  localparam int CFG_DW   = 32;

  // Register reset values
  localparam logic [THR_W-1:0]  PEAK_THR_RST  = 12'd20;
  localparam logic [THR_W-1:0]  STEP_THR_RST  = 12'd10;
  localparam logic [CNT_W-1:0]  MIN_RISE_RST  = 9'd5;
  localparam logic [CNT_W-1:0]  WIN_START_RST = 9'd1;
  localparam logic [WEND_W-1:0] WIN_END_RST   = 10'd512;

  typedef enum logic [2:0] {
    REG_PEAK_THR  = 3'd0,
    REG_STEP_THR  = 3'd1,
    REG_MIN_RISE  = 3'd2,
    REG_WIN_START = 3'd3,
    REG_WIN_END   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [THR_W-1:0]  peak_threshold;
    logic [THR_W-1:0]  step_threshold;
    logic [CNT_W-1:0]  min_rising;
    logic [CNT_W-1:0]  window_start;
    logic [WEND_W-1:0] window_end;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last_sample;
  } sample_in_t;

  typedef struct packed {
    logic                is_peak;
    logic [IDX_W-1:0]    peak_index;
    logic [IDX_W-1:0]    start_index;
    logic [SAMPLE_W-1:0] peak_value;
    logic                overflow;
    logic                last_result;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_CHECK,
    S_RD_A,
    S_STEP,
    S_LEVEL,
    S_MINR,
    S_BEFORE,
    S_THR,
    S_WALK_RD,
    S_WALK_CMP,
    S_EMIT,
    S_DONE
  } scan_state_t;

  // Sign-extend a sample to compare-unit width, optionally scaled by 2**sh
  function automatic logic signed [ALU_W-1:0] sx_sample(input logic [SAMPLE_W-1:0] v,
                                                       input logic [2:0] sh);
    logic signed [ALU_W-1:0] e;
    e = {{(ALU_W-SAMPLE_W){v[SAMPLE_W-1]}}, v};
    return e <<< sh;
  endfunction

  function automatic logic signed [ALU_W-1:0] zx_thr(input logic [THR_W-1:0] v);
    return {{(ALU_W-THR_W){1'b0}}, v};
  endfunction

endpackage

@@ sv/rep_sample_mem.sv @@
module rep_sample_mem
  import rep_pkg::*;
#(
  parameter int DEPTH = 512
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [SAMPLE_W-1:0]        wr_data,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [SAMPLE_W-1:0]        rd_data
);

  logic [SAMPLE_W-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ sv/rep_cmp_unit.sv @@
module rep_cmp_unit
  import rep_pkg::*;
(
  input  logic signed [ALU_W-1:0] x,
  input  logic signed [ALU_W-1:0] y,
  input  logic signed [ALU_W-1:0] z,
  output logic                    gt
);

  logic signed [ALU_W:0] diff;
  logic signed [ALU_W:0] z_ext;

  // Shared subtract and compare: (x - y) > z
  always_comb begin
    diff  = {x[ALU_W-1], x} - {y[ALU_W-1], y};
    z_ext = {z[ALU_W-1], z};
    gt    = diff > z_ext;
  end

endmodule

@@ sv/rep_cfg_regs.sv @@
module rep_cfg_regs
  import rep_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic     wr_stb;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_stb = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);

  // Register writes on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.peak_threshold <= PEAK_THR_RST;
      cfg.step_threshold <= STEP_THR_RST;
      cfg.min_rising     <= MIN_RISE_RST;
      cfg.window_start   <= WIN_START_RST;
      cfg.window_end     <= WIN_END_RST;
    end else if (wr_stb) begin
      unique case (idx)
        REG_PEAK_THR:  cfg.peak_threshold <= pwdata[THR_W-1:0];
        REG_STEP_THR:  cfg.step_threshold <= pwdata[THR_W-1:0];
        REG_MIN_RISE:  cfg.min_rising     <= pwdata[CNT_W-1:0];
        REG_WIN_START: cfg.window_start   <= pwdata[CNT_W-1:0];
        REG_WIN_END:   cfg.window_end     <= pwdata[WEND_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      REG_PEAK_THR:  prdata = {{(CFG_DW-THR_W){1'b0}}, cfg.peak_threshold};
      REG_STEP_THR:  prdata = {{(CFG_DW-THR_W){1'b0}}, cfg.step_threshold};
      REG_MIN_RISE:  prdata = {{(CFG_DW-CNT_W){1'b0}}, cfg.min_rising};
      REG_WIN_START: prdata = {{(CFG_DW-CNT_W){1'b0}}, cfg.window_start};
      REG_WIN_END:   prdata = {{(CFG_DW-WEND_W){1'b0}}, cfg.window_end};
      default:       prdata = '0;
    endcase
  end

endmodule

@@ sv/rep_scan_ctrl.sv @@
module rep_scan_ctrl
  import rep_pkg::*;
#(
  parameter int DEPTH     = 512,
  parameter int MAX_PEAKS = 63
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  sample_in_t                  item,
  input  cfg_t                        cfg,
  output logic                        mem_wr_en,
  output logic [$clog2(DEPTH)-1:0]    mem_wr_addr,
  output logic [SAMPLE_W-1:0]         mem_wr_data,
  output logic [$clog2(DEPTH)-1:0]    mem_rd_addr,
  input  logic [SAMPLE_W-1:0]         mem_rd_data,
  output logic signed [ALU_W-1:0]     alu_x,
  output logic signed [ALU_W-1:0]     alu_y,
  output logic signed [ALU_W-1:0]     alu_z,
  input  logic                        alu_gt,
  output logic                        result_valid,
  output result_t                     result
);

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);
  localparam int CW = (LW > WEND_W) ? LW : WEND_W;
  localparam int PW = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS + 1) : 1;

  scan_state_t         state, state_next;
  logic [LW-1:0]       loaded, loaded_next;
  logic [CW-1:0]       scan, scan_next;
  logic [CW-1:0]       end_idx, end_idx_next;
  logic [CW-1:0]       above, above_next;
  logic [CW-1:0]       below, below_next;
  logic [CW-1:0]       p_idx, p_idx_next;
  logic [CW-1:0]       t_idx, t_idx_next;
  logic [PW-1:0]       peaks, peaks_next;
  logic                ovf, ovf_next;
  logic [SAMPLE_W-1:0] b_val, b_val_next;
  logic [SAMPLE_W-1:0] a_val, a_val_next;
  result_t             result_next;
  logic                result_valid_next;

  logic [CW-1:0]       first_idx;
  logic [CW-1:0]       min_rise;
  logic [CW-1:0]       wend;
  logic [CW-1:0]       loaded_w;
  logic [CW:0]         run;
  logic [CW:0]         cur_ext;
  logic [CW:0]         before_w;
  logic [CW-1:0]       prev_idx;

  assign busy = (state != S_IDLE);

  // Derived scan quantities
  always_comb begin
    first_idx = (cfg.window_start == '0) ? CW'(1) : CW'(cfg.window_start);
    min_rise  = (cfg.min_rising == '0) ? CW'(1) : CW'(cfg.min_rising);
    wend      = CW'(cfg.window_end);
    loaded_w  = CW'(loaded);
    run       = {1'b0, above} + {1'b0, below};
    cur_ext   = {1'b0, scan};
    before_w  = (run < cur_ext) ? (cur_ext - (CW + 1)'(1) - run) : '0;
    prev_idx  = scan - CW'(1);
  end

  // State and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      loaded       <= '0;
      scan         <= '0;
      above        <= '0;
      below        <= '0;
      peaks        <= '0;
      ovf          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      loaded       <= loaded_next;
      scan         <= scan_next;
      above        <= above_next;
      below        <= below_next;
      peaks        <= peaks_next;
      ovf          <= ovf_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    end_idx <= end_idx_next;
    p_idx   <= p_idx_next;
    t_idx   <= t_idx_next;
    b_val   <= b_val_next;
    a_val   <= a_val_next;
    result  <= result_next;
  end

  // Sequencer
  always_comb begin
    state_next        = state;
    loaded_next       = loaded;
    scan_next         = scan;
    end_idx_next      = end_idx;
    above_next        = above;
    below_next        = below;
    p_idx_next        = p_idx;
    t_idx_next        = t_idx;
    peaks_next        = peaks;
    ovf_next          = ovf;
    b_val_next        = b_val;
    a_val_next        = a_val;
    result_next       = result;
    result_valid_next = 1'b0;
    mem_wr_en         = 1'b0;
    mem_wr_addr       = loaded[AW-1:0];
    mem_wr_data       = item.sample;
    mem_rd_addr       = '0;
    alu_x             = '0;
    alu_y             = '0;
    alu_z             = '0;

    unique case (state)
      S_IDLE: begin
        // Load one sample per transaction; overflowing samples are dropped
        if (start) begin
          if (loaded < LW'(DEPTH)) begin
            mem_wr_en   = 1'b1;
            loaded_next = loaded + LW'(1);
          end
          if (item.last_sample) begin
            state_next = S_INIT;
          end
        end
      end

      S_INIT: begin
        scan_next    = first_idx;
        end_idx_next = (wend < loaded_w) ? wend : loaded_w;
        above_next   = '0;
        below_next   = '0;
        peaks_next   = '0;
        ovf_next     = 1'b0;
        state_next   = S_CHECK;
      end

      S_CHECK: begin
        if (scan < end_idx) begin
          mem_rd_addr = prev_idx[AW-1:0];
          state_next  = S_RD_A;
        end else begin
          state_next  = S_DONE;
        end
      end

      S_RD_A: begin
        b_val_next  = mem_rd_data;
        mem_rd_addr = scan[AW-1:0];
        state_next  = S_STEP;
      end

      S_STEP: begin
        // a - b > step threshold
        alu_x      = sx_sample(mem_rd_data, 3'd0);
        alu_y      = sx_sample(b_val, 3'd0);
        alu_z      = zx_thr(cfg.step_threshold);
        a_val_next = mem_rd_data;
        state_next = alu_gt ? S_LEVEL : S_MINR;
      end

      S_LEVEL: begin
        // a > peak threshold
        alu_x = sx_sample(a_val, 3'd0);
        alu_z = zx_thr(cfg.peak_threshold);
        if (alu_gt) begin
          above_next = above + CW'(1);
        end else begin
          below_next = below + CW'(1);
        end
        scan_next  = scan + CW'(1);
        state_next = S_CHECK;
      end

      S_MINR: begin
        if (above < min_rise) begin
          above_next = '0;
          below_next = '0;
          scan_next  = scan + CW'(1);
          state_next = S_CHECK;
        end else if (below >= above) begin
          mem_rd_addr = before_w[AW-1:0];
          state_next  = S_BEFORE;
        end else begin
          state_next  = S_THR;
        end
      end

      S_BEFORE: begin
        // -sample[before] > b rejects the candidate
        alu_y = sx_sample(mem_rd_data, 3'd0);
        alu_z = sx_sample(b_val, 3'd0);
        if (alu_gt) begin
          above_next = '0;
          below_next = '0;
          scan_next  = scan + CW'(1);
          state_next = S_CHECK;
        end else begin
          state_next = S_THR;
        end
      end

      S_THR: begin
        // threshold > b: peak too low, keep scanning
        alu_x = zx_thr(cfg.peak_threshold);
        alu_z = sx_sample(b_val, 3'd0);
        if (alu_gt) begin
          above_next = '0;
          below_next = '0;
          scan_next  = scan + CW'(1);
          state_next = S_CHECK;
        end else if (peaks >= PW'(MAX_PEAKS)) begin
          ovf_next   = 1'b1;
          state_next = S_DONE;
        end else begin
          p_idx_next = prev_idx;
          t_idx_next = (above <= prev_idx) ? (prev_idx - above) : '0;
          state_next = S_WALK_RD;
        end
      end

      S_WALK_RD: begin
        if (t_idx < p_idx) begin
          mem_rd_addr = t_idx[AW-1:0];
          state_next  = S_WALK_CMP;
        end else begin
          state_next  = S_EMIT;
        end
      end

      S_WALK_CMP: begin
        // b - 16s > 4s  <=>  20s < b
        alu_x = sx_sample(b_val, 3'd0);
        alu_y = sx_sample(mem_rd_data, 3'd4);
        alu_z = sx_sample(mem_rd_data, 3'd2);
        if (alu_gt) begin
          t_idx_next = t_idx + CW'(1);
          state_next = S_WALK_RD;
        end else begin
          state_next = S_EMIT;
        end
      end

      S_EMIT: begin
        result_next.is_peak     = 1'b1;
        result_next.peak_index  = p_idx[IDX_W-1:0];
        result_next.start_index = t_idx[IDX_W-1:0];
        result_next.peak_value  = b_val;
        result_next.overflow    = 1'b0;
        result_next.last_result = 1'b0;
        result_valid_next       = 1'b1;
        peaks_next              = peaks + PW'(1);
        above_next              = '0;
        below_next              = '0;
        scan_next               = p_idx;
        state_next              = S_CHECK;
      end

      S_DONE: begin
        result_next.is_peak     = 1'b0;
        result_next.peak_index  = '0;
        result_next.start_index = '0;
        result_next.peak_value  = '0;
        result_next.overflow    = ovf;
        result_next.last_result = 1'b1;
        result_valid_next       = 1'b1;
        loaded_next             = '0;
        scan_next               = '0;
        above_next              = '0;
        below_next              = '0;
        state_next              = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ sv/rising_edge_peak_finder.sv @@
// Rising-edge peak finder.
// Samples arrive on item, one transaction per cycle while busy is low
// (start high, busy low). Each sample is written to the sample store; ones
// past DEPTH are dropped. The transaction with last_sample set starts a scan
// of the configured window and busy rises the next cycle.
// The scan reports each peak as a result with is_peak set, then one closing
// transaction with last_result set (and overflow when a peak past MAX_PEAKS
// was found). result_valid is high for exactly one cycle per result; the
// receiver cannot stall, so results must be taken as they come.
// A scan sets up the window, then for each index reads the previous and
// current sample and tests the step, then the level or the rise count,
// the sample before the run and the peak threshold; a reported peak adds
// a walk to its start index and an emit step. The single read port of the
// sample store and the one shared subtract/compare unit serialise the steps.
// Reset is synchronous: control and configuration registers go to their
// defaults, the load count is cleared and the block returns to idle. The
// store is not cleared; the scan reads only samples of the current waveform.
// Configuration is an APB-style port, register i at byte address 4*i.
module rising_edge_peak_finder
  import rep_pkg::*;
#(
  parameter int DEPTH     = 512,
  parameter int MAX_PEAKS = 63
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  sample_in_t        item,
  output logic              result_valid,
  output result_t           result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int AW = $clog2(DEPTH);

  cfg_t                    cfg;
  logic                    mem_wr_en;
  logic [AW-1:0]           mem_wr_addr;
  logic [SAMPLE_W-1:0]     mem_wr_data;
  logic [AW-1:0]           mem_rd_addr;
  logic [SAMPLE_W-1:0]     mem_rd_data;
  logic signed [ALU_W-1:0] alu_x;
  logic signed [ALU_W-1:0] alu_y;
  logic signed [ALU_W-1:0] alu_z;
  logic                    alu_gt;

  rep_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rep_sample_mem #(.DEPTH(DEPTH)) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  rep_cmp_unit u_cmp (
    .x  (alu_x),
    .y  (alu_y),
    .z  (alu_z),
    .gt (alu_gt)
  );

  rep_scan_ctrl #(.DEPTH(DEPTH), .MAX_PEAKS(MAX_PEAKS)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .cfg          (cfg),
    .mem_wr_en    (mem_wr_en),
    .mem_wr_addr  (mem_wr_addr),
    .mem_wr_data  (mem_wr_data),
    .mem_rd_addr  (mem_rd_addr),
    .mem_rd_data  (mem_rd_data),
    .alu_x        (alu_x),
    .alu_y        (alu_y),
    .alu_z        (alu_z),
    .alu_gt       (alu_gt),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

@@ sv/rep_checker.sv @@
module rep_checker
  import rep_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input sample_in_t item,
  input logic       result_valid,
  input result_t    result
);

  // A last sample starts the scan
  assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.last_sample |=> busy)
    else $error("scan did not start after last sample");

  // Peak results come while the scan still runs
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last_result |-> busy)
    else $error("peak result outside a scan");

  // The closing transaction ends the scan
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_result |-> !busy && $past(busy))
    else $error("done transaction not at end of scan");

  // Peak results never carry done or overflow marks
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.is_peak |-> !result.overflow && !result.last_result)
    else $error("peak result with done flags");

  // Results never come in back-to-back cycles
  assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("back-to-back results");

endmodule

bind rising_edge_peak_finder rep_checker u_rep_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .item         (item),
  .result_valid (result_valid),
  .result       (result)
);
